[rtl/core/i2p_pkg.sv]
package i2p_pkg;

	// ascii codes of the characters with a meaning of their own
	localparam logic [7:0] CH_OPEN  = 8'd40;
	localparam logic [7:0] CH_CLOSE = 8'd41;
	localparam logic [7:0] CH_MUL   = 8'd42;
	localparam logic [7:0] CH_ADD   = 8'd43;
	localparam logic [7:0] CH_SUB   = 8'd45;
	localparam logic [7:0] CH_DIV   = 8'd47;
	localparam logic [7:0] CH_POW   = 8'd94;

	// result status codes
	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_UNMATCHED = 2'd1;
	localparam logic [1:0] STAT_OVERFLOW  = 2'd2;

	// results per request are capped
	localparam int unsigned MAX_RESULTS = 16;
	localparam int unsigned RES_W       = $clog2(MAX_RESULTS + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_PUSH,
		ST_ERR,
		ST_DONE
	} state_t;

	function automatic logic is_operator(input logic [7:0] c);
		return (c == CH_ADD) || (c == CH_SUB) || (c == CH_MUL) ||
			(c == CH_DIV) || (c == CH_POW);
	endfunction

	// '(' and anything else rank lowest
	function automatic logic [1:0] prec_of(input logic [7:0] c);
		logic [1:0] p;
		p = 2'd0;
		if ((c == CH_ADD) || (c == CH_SUB)) p = 2'd1;
		if ((c == CH_MUL) || (c == CH_DIV)) p = 2'd2;
		if (c == CH_POW) p = 2'd3;
		return p;
	endfunction

endpackage

[rtl/core/infix_to_postfix_converter.sv]
// Shunting-yard infix to postfix converter. Each request carries one ASCII character
// (or an end marker when end_of_expression is set); results are postfix characters,
// with last_of_run marking the final result caused by that request. A request that
// only pushes produces no result. Operands are accepted and finished. '(' and an
// operator that meets an empty stack are accepted, pushed and finished. Each entry
// inspected on the operator stack takes a read step and then an evaluate step, since
// the stack memory has one registered read port at the top-of-stack address; a push
// or an error result adds a step of its own after them. The block takes no new request
// while one is in work. Result stall stretches this: each result waits
// in a one-deep hold register until the output register frees up. Errors come out
// as out_symbol 0 with status 1 (unmatched ')', the stack ends empty) or status 2
// (push onto a full stack, the symbol is dropped). At most 16 results are given
// per request; further pops still happen but are not reported.
module infix_to_postfix_converter #(
	parameter int unsigned STACK_DEPTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	// request channel
	input  logic       symbol_valid,
	output logic       symbol_stall,
	input  logic [7:0] symbol,
	input  logic       end_of_expression,
	// result channel
	output logic       result_valid,
	input  logic       result_stall,
	output logic [7:0] out_symbol,
	output logic [1:0] status,
	output logic       last_of_run
);

	localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
	localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	// sequencer state
	i2p_pkg::state_t state_q, state_nxt;

	// request being worked on
	logic [7:0]              sym_q;
	logic                    end_q;
	logic [i2p_pkg::RES_W-1:0] n_q;   // results taken for this request

	// operator stack: memory with one write and one registered read port
	logic [7:0]    stack_mem [STACK_DEPTH];
	logic [CW-1:0] count_q;
	logic [7:0]    rd_q;
	logic [CW-1:0] top_idx;

	// one-deep hold for the newest result, so last_of_run can be set later
	logic       pend_valid_q;
	logic [7:0] pend_sym_q;
	logic [1:0] pend_status_q;

	// output register
	logic       out_valid_q;
	logic [7:0] out_sym_q;
	logic [1:0] out_status_q;
	logic       out_last_q;

	// decisions of the current cycle
	logic       accept;
	logic       emit_req;
	logic [7:0] emit_sym;
	logic [1:0] emit_status;
	logic       emit_take;
	logic       emit_block;
	logic       can_out;
	logic       pop;
	logic       push_wr;
	logic       load_out;
	logic       count_one;
	logic       count_zero;
	logic       stack_full;
	logic       in_operand;

	assign top_idx    = count_q - CW'(1);
	assign count_one  = (count_q == CW'(1));
	assign count_zero = (count_q == '0);
	assign stack_full = (count_q >= CW'(STACK_DEPTH));
	assign can_out    = !out_valid_q || !result_stall;

	assign symbol_stall = (state_q != i2p_pkg::ST_IDLE);
	assign accept       = symbol_valid && !symbol_stall;
	assign in_operand   = !end_of_expression && (symbol != i2p_pkg::CH_OPEN) &&
		(symbol != i2p_pkg::CH_CLOSE) && !i2p_pkg::is_operator(symbol);

	// results past the cap are dropped, so they never wait; an operand in idle
	// is the first result of a fresh request
	assign emit_take  = emit_req && ((state_q == i2p_pkg::ST_IDLE) ||
		(n_q < i2p_pkg::RES_W'(i2p_pkg::MAX_RESULTS)));
	// a new result needs the hold register emptied into the output register
	assign emit_block = emit_take && pend_valid_q && !can_out;

	// per-state actions
	always_comb begin
		emit_req    = 1'b0;
		emit_sym    = rd_q;
		emit_status = i2p_pkg::STAT_OK;
		pop         = 1'b0;
		push_wr     = 1'b0;
		case (state_q)
			i2p_pkg::ST_IDLE: begin
				// operands go straight out; the hold register is empty here
				emit_req = accept && in_operand;
				emit_sym = symbol;
			end
			i2p_pkg::ST_EVAL: begin
				if (end_q) begin
					// flush: '(' entries vanish silently
					pop      = 1'b1;
					emit_req = (rd_q != i2p_pkg::CH_OPEN);
				end else if (sym_q == i2p_pkg::CH_CLOSE) begin
					pop      = 1'b1;
					emit_req = (rd_q != i2p_pkg::CH_OPEN);
				end else if ((i2p_pkg::prec_of(rd_q) >= i2p_pkg::prec_of(sym_q)) &&
					(rd_q != i2p_pkg::CH_OPEN)) begin
					pop      = 1'b1;
					emit_req = 1'b1;
				end
			end
			i2p_pkg::ST_PUSH: begin
				if (stack_full) begin
					emit_req    = 1'b1;
					emit_sym    = 8'd0;
					emit_status = i2p_pkg::STAT_OVERFLOW;
				end else begin
					push_wr = 1'b1;
				end
			end
			i2p_pkg::ST_ERR: begin
				emit_req    = 1'b1;
				emit_sym    = 8'd0;
				emit_status = i2p_pkg::STAT_UNMATCHED;
			end
			default: begin
			end
		endcase
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			i2p_pkg::ST_IDLE: begin
				if (accept) begin
					if (end_of_expression) begin
						state_nxt = count_zero ? i2p_pkg::ST_DONE : i2p_pkg::ST_READ;
					end else if (symbol == i2p_pkg::CH_OPEN) begin
						state_nxt = i2p_pkg::ST_PUSH;
					end else if (i2p_pkg::is_operator(symbol)) begin
						state_nxt = count_zero ? i2p_pkg::ST_PUSH : i2p_pkg::ST_READ;
					end else if (symbol == i2p_pkg::CH_CLOSE) begin
						state_nxt = count_zero ? i2p_pkg::ST_ERR : i2p_pkg::ST_READ;
					end else begin
						state_nxt = i2p_pkg::ST_DONE;
					end
				end
			end
			i2p_pkg::ST_READ: begin
				state_nxt = i2p_pkg::ST_EVAL;
			end
			i2p_pkg::ST_EVAL: begin
				if (!emit_block) begin
					if (end_q) begin
						state_nxt = count_one ? i2p_pkg::ST_DONE : i2p_pkg::ST_READ;
					end else if (sym_q == i2p_pkg::CH_CLOSE) begin
						if (rd_q == i2p_pkg::CH_OPEN) begin
							state_nxt = i2p_pkg::ST_DONE;
						end else begin
							state_nxt = count_one ? i2p_pkg::ST_ERR : i2p_pkg::ST_READ;
						end
					end else if (pop) begin
						state_nxt = count_one ? i2p_pkg::ST_PUSH : i2p_pkg::ST_READ;
					end else begin
						state_nxt = i2p_pkg::ST_PUSH;
					end
				end
			end
			i2p_pkg::ST_PUSH, i2p_pkg::ST_ERR: begin
				if (!emit_block) begin
					state_nxt = i2p_pkg::ST_DONE;
				end
			end
			i2p_pkg::ST_DONE: begin
				if (!pend_valid_q || can_out) begin
					state_nxt = i2p_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = i2p_pkg::ST_IDLE;
			end
		endcase
	end

	// the held result moves out either to make room or as the last of the run
	assign load_out = pend_valid_q && can_out &&
		((emit_take && !emit_block) || (state_q == i2p_pkg::ST_DONE));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= i2p_pkg::ST_IDLE;
			count_q      <= '0;
			n_q          <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q     <= state_nxt;
			out_valid_q <= load_out || (out_valid_q && result_stall);

			if (pop && !emit_block) begin
				count_q <= count_q - CW'(1);
			end else if (push_wr) begin
				count_q <= count_q + CW'(1);
			end

			if (accept) begin
				n_q <= emit_take ? i2p_pkg::RES_W'(1) : '0;
			end else if (emit_take && !emit_block) begin
				n_q <= n_q + i2p_pkg::RES_W'(1);
			end

			if (emit_take && !emit_block) begin
				pend_valid_q <= 1'b1;
			end else if ((state_q == i2p_pkg::ST_DONE) && can_out) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			sym_q <= symbol;
			end_q <= end_of_expression;
		end
		if (emit_take && !emit_block) begin
			pend_sym_q    <= emit_sym;
			pend_status_q <= emit_status;
		end
		if (load_out) begin
			out_sym_q    <= pend_sym_q;
			out_status_q <= pend_status_q;
			out_last_q   <= (state_q == i2p_pkg::ST_DONE);
		end
	end

	// stack memory
	always_ff @(posedge clk) begin
		if (push_wr) begin
			stack_mem[count_q[AW-1:0]] <= sym_q;
		end
		rd_q <= stack_mem[top_idx[AW-1:0]];
	end

	assign result_valid = out_valid_q;
	assign out_symbol   = out_sym_q;
	assign status       = out_status_q;
	assign last_of_run  = out_last_q;

endmodule

[test/postfix_checker.sv]
`timescale 1ns / 100ps

module postfix_checker #(
	parameter int unsigned STACK_N = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        symbol_valid,
	input  logic        symbol_stall,
	input  logic [7:0]  symbol,
	input  logic        end_of_expression,
	input  logic        result_valid,
	input  logic        result_stall,
	input  logic [7:0]  out_symbol,
	input  logic [1:0]  status,
	input  logic        last_of_run,
	output int unsigned pending,
	output int unsigned checked,
	output int unsigned mismatches
);

	typedef struct packed {
		logic [7:0] sym;
		logic [1:0] stat;
		logic       last;
	} postfix_out_t;

	logic [7:0]   op_stack [STACK_N];
	int unsigned  op_depth;
	postfix_out_t postfix_q [$];
	postfix_out_t fresh [$];
	postfix_out_t seen;
	postfix_out_t want;

	function automatic int unsigned rank(input logic [7:0] c);
		case (c)
			i2p_pkg::CH_ADD, i2p_pkg::CH_SUB: return 1;
			i2p_pkg::CH_MUL, i2p_pkg::CH_DIV: return 2;
			i2p_pkg::CH_POW:                  return 3;
			default:                          return 0;
		endcase
	endfunction

	function automatic logic arith_op(input logic [7:0] c);
		case (c)
			i2p_pkg::CH_ADD, i2p_pkg::CH_SUB, i2p_pkg::CH_MUL, i2p_pkg::CH_DIV,
			i2p_pkg::CH_POW: return 1'b1;
			default:         return 1'b0;
		endcase
	endfunction

	// results beyond the per-request cap are dropped
	function automatic void put(input logic [7:0] s, input logic [1:0] st);
		if (fresh.size() < i2p_pkg::MAX_RESULTS)
			fresh.push_back('{s, st, 1'b0});
	endfunction

	function automatic void push_entry(input logic [7:0] ch);
		if (op_depth >= STACK_N) begin
			put(8'd0, i2p_pkg::STAT_OVERFLOW);
		end else begin
			op_stack[op_depth] = ch;
			op_depth++;
		end
	endfunction

	function automatic void shunt(input logic [7:0] ch, input logic fin);
		logic [7:0] e;
		logic       matched;
		fresh.delete();
		if (fin) begin
			while (op_depth > 0) begin
				op_depth--;
				e = op_stack[op_depth];
				if (e != i2p_pkg::CH_OPEN)
					put(e, i2p_pkg::STAT_OK);
			end
		end else if (ch == i2p_pkg::CH_OPEN) begin
			push_entry(ch);
		end else if (arith_op(ch)) begin
			while (op_depth > 0 && rank(op_stack[op_depth - 1]) >= rank(ch)) begin
				put(op_stack[op_depth - 1], i2p_pkg::STAT_OK);
				op_depth--;
			end
			push_entry(ch);
		end else if (ch == i2p_pkg::CH_CLOSE) begin
			matched = 1'b0;
			while (op_depth > 0 && !matched) begin
				op_depth--;
				e = op_stack[op_depth];
				if (e == i2p_pkg::CH_OPEN)
					matched = 1'b1;
				else
					put(e, i2p_pkg::STAT_OK);
			end
			if (!matched)
				put(8'd0, i2p_pkg::STAT_UNMATCHED);
		end else begin
			put(ch, i2p_pkg::STAT_OK);
		end
		if (fresh.size() > 0)
			fresh[fresh.size() - 1].last = 1'b1;
		foreach (fresh[i])
			postfix_q.push_back(fresh[i]);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			postfix_q.delete();
			op_depth = 0;
			pending    <= 0;
			checked    <= 0;
			mismatches <= 0;
		end else begin
			// results seen at this edge belong to earlier requests
			if (result_valid && !result_stall) begin
				seen = '{out_symbol, status, last_of_run};
				if (postfix_q.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: unexpected result sym %02h status %0d last %0b",
							$realtime, out_symbol, status, last_of_run);
					mismatches <= mismatches + 1;
				end else begin
					want = postfix_q.pop_front();
					if (seen !== want) begin
						if (mismatches < 10)
							$display({"%0t: postfix mismatch exp sym %02h status %0d ",
								"last %0b, got sym %02h status %0d last %0b"},
								$realtime, want.sym, want.stat, want.last,
								seen.sym, seen.stat, seen.last);
						mismatches <= mismatches + 1;
					end
					checked <= checked + 1;
				end
			end
			if (symbol_valid && !symbol_stall)
				shunt(symbol, end_of_expression);
			pending <= postfix_q.size();
		end
	end

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

	localparam int unsigned STACK_DEPTH   = 16;
	// cycles with no request and no result taken before giving up
	localparam int unsigned QUIET_LIMIT   = 2000;
	// longest request walks the whole stack
	localparam int unsigned SETTLE_CYCLES = 100;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        symbol_valid;
	logic        symbol_stall;
	logic [7:0]  symbol;
	logic        end_of_expression;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [7:0]  out_symbol;
	logic [1:0]  status;
	logic        last_of_run;

	int unsigned pending;
	int unsigned checked;
	int unsigned mismatches;

	int unsigned send_pct;
	int unsigned stall_pct = 0;
	int unsigned sent;
	int unsigned quiet = 0;

	infix_to_postfix_converter #(
		.STACK_DEPTH(STACK_DEPTH)
	) i_dut (.*);

	postfix_checker #(
		.STACK_N(STACK_DEPTH)
	) i_checker (.*);

	always #5 clk = ~clk;

	// receiver back-pressure, redrawn every cycle
	always @(posedge clk) begin
		result_stall <= ($urandom_range(99) < stall_pct);
	end

	// watchdog: any accepted request or result resets the count
	always @(posedge clk) begin
		if (!arst_n || (symbol_valid && !symbol_stall) || (result_valid && !result_stall)) begin
			quiet <= 0;
		end else if (quiet == QUIET_LIMIT) begin
			$display("infix_to_postfix_converter verification failed");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	function automatic logic [7:0] pick_operator(input int unsigned k);
		case (k)
			0:       return i2p_pkg::CH_ADD;
			1:       return i2p_pkg::CH_MUL;
			2:       return i2p_pkg::CH_POW;
			3:       return i2p_pkg::CH_DIV;
			default: return i2p_pkg::CH_SUB;
		endcase
	endfunction

	// any byte that is neither an operator nor a parenthesis
	function automatic logic [7:0] pick_operand();
		logic [7:0] c;
		logic       special;
		do begin
			c = 8'($urandom_range(255));
			case (c)
				i2p_pkg::CH_OPEN, i2p_pkg::CH_CLOSE, i2p_pkg::CH_ADD, i2p_pkg::CH_SUB,
				i2p_pkg::CH_MUL, i2p_pkg::CH_DIV, i2p_pkg::CH_POW: special = 1'b1;
				default:                                          special = 1'b0;
			endcase
		end while (special);
		return c;
	endfunction

	// one request: optional idle gap, then hold until taken
	task automatic send_req(input logic [7:0] ch, input logic fin);
		while ($urandom_range(99) < send_pct) begin
			symbol_valid <= 1'b0;
			@(posedge clk);
		end
		symbol_valid      <= 1'b1;
		symbol            <= ch;
		end_of_expression <= fin;
		@(posedge clk);
		while (symbol_stall)
			@(posedge clk);
		sent++;
	endtask

	// well-formed expression with random operands, operators and nesting,
	// closed by an end marker carrying a random (ignored) symbol
	task automatic send_expr();
		int unsigned terms;
		int unsigned nest;
		terms = $urandom_range(1, 6);
		nest  = 0;
		while (terms > 0) begin
			while (nest < 5 && $urandom_range(3) == 0) begin
				send_req(i2p_pkg::CH_OPEN, 1'b0);
				nest++;
			end
			send_req(pick_operand(), 1'b0);
			while (nest > 0 && $urandom_range(2) == 0) begin
				send_req(i2p_pkg::CH_CLOSE, 1'b0);
				nest--;
			end
			terms--;
			if (terms > 0)
				send_req(pick_operator($urandom_range(4)), 1'b0);
		end
		while (nest > 0) begin
			send_req(i2p_pkg::CH_CLOSE, 1'b0);
			nest--;
		end
		send_req(8'($urandom_range(255)), 1'b1);
	endtask

	// broken sequences: stray operators, parentheses, bytes and end markers
	task automatic send_noise();
		int unsigned n;
		int unsigned r;
		n = $urandom_range(1, 6);
		repeat (n) begin
			r = $urandom_range(9);
			case (r)
				0, 1, 2, 3: send_req(pick_operator($urandom_range(4)), 1'b0);
				4, 5:       send_req(i2p_pkg::CH_OPEN, 1'b0);
				6, 7:       send_req(i2p_pkg::CH_CLOSE, 1'b0);
				8:          send_req(8'($urandom_range(255)), 1'b0);
				default:    send_req(8'($urandom_range(255)), 1'b1);
			endcase
		end
	endtask

	task automatic send_random();
		if ($urandom_range(3) == 0)
			send_noise();
		else
			send_expr();
	endtask

	// sender holds off until every predicted result has come back
	task automatic drain();
		symbol_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin
		int unsigned k;
		arst_n            = 1'b0;
		symbol_valid      = 1'b0;
		symbol            = 8'd0;
		end_of_expression = 1'b0;
		send_pct          = 10;
		sent              = 0;
		stall_pct        <= 55;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// null and all-ones bytes are plain operands
		send_req(8'h00, 1'b0);
		send_req(8'hFF, 1'b0);
		// close with nothing stacked
		send_req(i2p_pkg::CH_CLOSE, 1'b0);
		// close that pops an operator and then finds no open parenthesis
		send_req("a", 1'b0);
		send_req(i2p_pkg::CH_POW, 1'b0);
		send_req("b", 1'b0);
		send_req(i2p_pkg::CH_CLOSE, 1'b0);
		// fill the stack with open parentheses and every operator, top is '+'
		for (k = 0; k < STACK_DEPTH / 2; k++) begin
			send_req(i2p_pkg::CH_OPEN, 1'b0);
			send_req(pick_operator((k + 3) % 5), 1'b0);
		end
		// '^' pops nothing and meets a full stack, so does '('
		send_req(i2p_pkg::CH_POW, 1'b0);
		send_req(i2p_pkg::CH_OPEN, 1'b0);
		// close pops '+' and drops its '('
		send_req(i2p_pkg::CH_CLOSE, 1'b0);
		// flush skips the leftover open parentheses
		send_req(8'hFF, 1'b1);

		// sender idles lightly, receiver stalls heavily
		while (sent < 80)
			send_random();
		drain();

		// the other way round
		send_pct   = 55;
		stall_pct <= 10;
		while (sent < 135)
			send_random();
		drain();

		// full rate on both sides
		send_pct   = 0;
		stall_pct <= 0;
		while (sent < 190)
			send_random();
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("%0d requests sent, %0d postfix results checked, %0d mismatches",
			sent, checked, mismatches);
		$display("covered precedence, parentheses, overflow, unmatched close, flush, three handshake mixes");
		if (mismatches == 0 && pending == 0)
			$display("infix_to_postfix_converter verification clean");
		else
			$display("infix_to_postfix_converter verification failed");
		$finish;
	end

endmodule
